// File: rtl/pblru_pkg.sv
// Package for the part buffer LRU slot selector.
// Holds sizes, shared types and the state encoding; it depends on nothing.
package pblru_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int TAG_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int ACT_W     = 5;
  localparam int SLOT_W    = 4;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

  typedef logic [IDX_W-1:0] idx_t;

  // Contents of one slot as seen by the scan.
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  // Update of one slot at the end of an item.
  typedef struct packed {
    logic               en;
    logic               fill;
    idx_t               idx;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } slot_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Index of the last live slot: a count of zero counts as one, and a count
  // above the slot total is saturated.
  function automatic idx_t last_slot(input logic [ACT_W-1:0] act);
    int n;
    n = int'(act);
    if (n == 0) begin
      n = 1;
    end
    if (n > NUM_SLOTS) begin
      n = NUM_SLOTS;
    end
    return idx_t'(n - 1);
  endfunction

endpackage

// File: rtl/pblru_store.sv
// Slot store: tag, valid mark and last-use stamp for every buffer slot.
// Depends on pblru_pkg for sizes and the read and write structs.
module pblru_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pblru_pkg::idx_t     rd_idx_i,
  output pblru_pkg::slot_t    rd_o,
  input  pblru_pkg::slot_wr_t wr_i
);

  logic [pblru_pkg::TAG_W-1:0]   tag_q   [pblru_pkg::NUM_SLOTS];
  logic [pblru_pkg::STAMP_W-1:0] stamp_q [pblru_pkg::NUM_SLOTS];
  logic [pblru_pkg::NUM_SLOTS-1:0] valid_q;

  // Valid marks clear at reset; tags and stamps are only looked at once
  // their slot has been filled, and a fill always writes both.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en && wr_i.fill) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      stamp_q[wr_i.idx] <= wr_i.stamp;
      if (wr_i.fill) begin
        tag_q[wr_i.idx] <= wr_i.tag;
      end
    end
  end

  assign rd_o.valid = valid_q[rd_idx_i];
  assign rd_o.tag   = tag_q[rd_idx_i];
  assign rd_o.stamp = stamp_q[rd_idx_i];

endmodule

// File: rtl/part_buffer_lru_select.sv
// Top level of the part buffer LRU slot selector.
// Depends on pblru_pkg and instantiates the slot store pblru_store.
//
// Usage:
// A request item is taken at a rising clock edge where start is high and
// busy is low; requested_part_i carries the compressed part number. The
// block then walks the live slots one per cycle through a single tag
// comparator and a single stamp comparator. The walk stops at the first
// valid slot whose tag matches; otherwise it covers every live slot while
// remembering the first empty slot and the slot with the smallest stamp.
// After the walk, ST_DONE updates the chosen slot (tag and valid on a miss,
// stamp always) and advances the use counter.
// The result item appears on slot_index_o and hit_o for exactly one cycle
// with done_o high. The result is registered, and a new item may start in
// the cycle that shows the result. The result has no back-pressure; the
// receiver must take it when done_o is high. The live slot count is written
// through cfg_we_i and cfg_wdata_i; the user must do so only while the block
// is idle, which the block itself does not enforce. Zero counts as one slot.
// Reset empties every slot, clears the use counter and sets the live count
// to 16.
module part_buffer_lru_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pblru_pkg::TAG_W-1:0]   requested_part_i,
  output logic [pblru_pkg::SLOT_W-1:0]  slot_index_o,
  output logic                          hit_o,
  output logic                          done_o,
  input  logic                          cfg_we_i,
  input  logic [pblru_pkg::ACT_W-1:0]   cfg_wdata_i
);

  pblru_pkg::state_e state_q, state_d;

  logic [pblru_pkg::ACT_W-1:0]   active_q;
  logic [pblru_pkg::STAMP_W-1:0] counter_q, counter_d;
  logic                          done_q, done_d;

  // Scan context of the item in flight.
  pblru_pkg::idx_t               idx_q, idx_d;
  pblru_pkg::idx_t               last_q, last_d;
  pblru_pkg::idx_t               hit_idx_q, hit_idx_d;
  pblru_pkg::idx_t               empty_idx_q, empty_idx_d;
  pblru_pkg::idx_t               min_idx_q, min_idx_d;
  logic [pblru_pkg::STAMP_W-1:0] min_stamp_q, min_stamp_d;
  logic [pblru_pkg::TAG_W-1:0]   want_q, want_d;
  logic                          hit_q, hit_d;
  logic                          empty_q, empty_d;

  // Result register.
  logic [pblru_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic                          res_hit_q, res_hit_d;

  pblru_pkg::slot_t    rd;
  pblru_pkg::slot_wr_t wr;
  pblru_pkg::idx_t     pick;
  logic                match;

  pblru_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  assign match = rd.valid && (rd.tag == want_q);

  // A hit wins, then the first empty slot, then the least recently used.
  assign pick = hit_q   ? hit_idx_q   :
                empty_q ? empty_idx_q : min_idx_q;

  always_comb begin
    state_d     = state_q;
    counter_d   = counter_q;
    done_d      = 1'b0;
    idx_d       = idx_q;
    last_d      = last_q;
    hit_idx_d   = hit_idx_q;
    empty_idx_d = empty_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    want_d      = want_q;
    hit_d       = hit_q;
    empty_d     = empty_q;
    slot_d      = slot_q;
    res_hit_d   = res_hit_q;
    wr          = '0;

    case (state_q)
      pblru_pkg::ST_IDLE: begin
        if (start) begin
          state_d = pblru_pkg::ST_SCAN;
          idx_d   = '0;
          last_d  = pblru_pkg::last_slot(active_q);
          want_d  = requested_part_i;
          hit_d   = 1'b0;
          empty_d = 1'b0;
        end
      end
      pblru_pkg::ST_SCAN: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
          state_d   = pblru_pkg::ST_DONE;
        end else begin
          if (!rd.valid && !empty_q) begin
            empty_d     = 1'b1;
            empty_idx_d = idx_q;
          end
          // Strict compare keeps the lowest index on equal stamps.
          if (rd.valid && ((idx_q == '0) || (rd.stamp < min_stamp_q))) begin
            min_stamp_d = rd.stamp;
            min_idx_d   = idx_q;
          end
          if (idx_q == last_q) begin
            state_d = pblru_pkg::ST_DONE;
          end else begin
            idx_d = idx_q + pblru_pkg::idx_t'(1);
          end
        end
      end
      pblru_pkg::ST_DONE: begin
        wr.en     = 1'b1;
        wr.fill   = !hit_q;
        wr.idx    = pick;
        wr.tag    = want_q;
        wr.stamp  = counter_q;
        counter_d = counter_q + pblru_pkg::STAMP_W'(1);
        slot_d    = pblru_pkg::SLOT_W'(pick);
        res_hit_d = hit_q;
        done_d    = 1'b1;
        state_d   = pblru_pkg::ST_IDLE;
      end
      default: begin
        state_d = pblru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pblru_pkg::ST_IDLE;
      active_q  <= pblru_pkg::ACT_RESET;
      counter_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    last_q      <= last_d;
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    want_q      <= want_d;
    hit_q       <= hit_d;
    empty_q     <= empty_d;
    slot_q      <= slot_d;
    res_hit_q   <= res_hit_d;
  end

  assign busy         = (state_q != pblru_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign slot_index_o = slot_q;
  assign hit_o        = res_hit_q;

endmodule

// File: rtl/pblru_chk.sv
// Port-level checker for the part buffer LRU slot selector.
// Depends on pblru_pkg for widths; bound to part_buffer_lru_select below.
module pblru_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         hit_o,
  input logic [pblru_pkg::SLOT_W-1:0] slot_index_o
);

  // An accepted item keeps the block busy in the following cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Every item ends with a result: busy only drops as the result shows.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("block went idle without a result");

  // A result is shown once the work is over, right after a busy cycle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result shown at the wrong time");

  // Each item passes through a scan state and a done state, so results never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // The result fields carry known values whenever the strobe is high.
  a_done_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown({hit_o, slot_index_o}))
    else $error("result fields unknown while the strobe is high");

endmodule

bind part_buffer_lru_select pblru_chk u_pblru_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .slot_index_o (slot_index_o)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for part_buffer_lru_select: slot lookup with least-recently-used refill.
// It depends on pblru_pkg and the RTL of the block. A predictor inside the bench
// supplies the expected slot and hit flag for every request item.
module tb_top;

  // Sender gaps are short on average. This limit covers the whole run several
  // times over.
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned ITEMS_PER_PHASE = 650;

  typedef struct packed {
    logic [pblru_pkg::SLOT_W-1:0] slot;
    logic                         hit;
  } pick_t;

  logic                         clk_i;
  logic                         rst_ni           = 1'b0;
  logic                         start            = 1'b0;
  logic [pblru_pkg::TAG_W-1:0]  requested_part_i = '0;
  logic                         cfg_we_i         = 1'b0;
  logic [pblru_pkg::ACT_W-1:0]  cfg_wdata_i      = '0;
  logic                         busy;
  logic [pblru_pkg::SLOT_W-1:0] slot_index_o;
  logic                         hit_o;
  logic                         done_o;

  part_buffer_lru_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .requested_part_i (requested_part_i),
    .slot_index_o     (slot_index_o),
    .hit_o            (hit_o),
    .done_o           (done_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // The bench keeps its own copy of the slot store. It starts from the
  // reset state. A part number is only compared when its slot is valid.
  logic [pblru_pkg::TAG_W-1:0]   held_part [pblru_pkg::NUM_SLOTS];
  logic                          held_valid[pblru_pkg::NUM_SLOTS];
  logic [pblru_pkg::STAMP_W-1:0] last_use  [pblru_pkg::NUM_SLOTS];
  logic [pblru_pkg::STAMP_W-1:0] use_count = '0;
  logic [pblru_pkg::ACT_W-1:0]   live_cfg  = pblru_pkg::ACT_RESET;

  // Expected results in order of acceptance. The block handles one item at a
  // time, so the results come back in that same order.
  pick_t                       pending_picks[$];
  logic [pblru_pkg::TAG_W-1:0] part_pool[$];

  int unsigned gap_pct     = 0;
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned results_in  = 0;
  int unsigned hits_seen   = 0;
  int unsigned cfg_writes  = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < pblru_pkg::NUM_SLOTS; i++) begin
      held_valid[i] = 1'b0;
      last_use[i]   = '0;
    end
  end

  // Predictor. It first looks for the lowest live valid slot that holds the
  // part. On a miss it takes the lowest empty live slot. If every live slot
  // is full, it takes the slot with the oldest stamp, and the lower index wins
  // a tie. Slots beyond the live count are never read or written.
  function automatic pick_t choose_slot(input logic [pblru_pkg::TAG_W-1:0] part);
    int    live;
    int    pick;
    bit    found;
    bit    empty;
    pick_t res;
    live = int'(live_cfg);
    if (live == 0) begin
      live = 1;
    end
    if (live > pblru_pkg::NUM_SLOTS) begin
      live = pblru_pkg::NUM_SLOTS;
    end
    found = 1'b0;
    empty = 1'b0;
    pick  = 0;
    for (int i = 0; i < live; i++) begin
      if (!found && held_valid[i] && held_part[i] == part) begin
        pick  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < live; i++) begin
        if (!empty && !held_valid[i]) begin
          pick  = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        pick = 0;
        for (int i = 1; i < live; i++) begin
          if (last_use[i] < last_use[pick]) begin
            pick = i;
          end
        end
      end
      held_part[pick]  = part;
      held_valid[pick] = 1'b1;
    end
    last_use[pick] = use_count;
    use_count      = use_count + pblru_pkg::STAMP_W'(1);
    res.slot = pblru_pkg::SLOT_W'(pick);
    res.hit  = found;
    return res;
  endfunction

  // Sends one request item. Before the item the sender may idle for a random
  // number of cycles. Start stays high from one item to the next when no gap
  // is drawn. The task returns in the time step of the accepting edge and
  // leaves start high there. Whatever comes next decides whether to lower it.
  task automatic send_part(input logic [pblru_pkg::TAG_W-1:0] part);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start            <= 1'b1;
    requested_part_i <= part;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    pending_picks.push_back(choose_slot(part));
    items_sent++;
  endtask

  // Lowers start and waits until every expected result has arrived and the
  // block is idle. Sampling on the falling edge keeps the wait independent of
  // when the checker pops its entry.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_picks.size() != 0 || busy !== 1'b0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // Writes the live slot count. This is only done while the block is idle.
  task automatic set_live_slots(input logic [pblru_pkg::ACT_W-1:0] count);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_cfg  = count;
    cfg_writes++;
  endtask

  // Each result is taken at the edge that ends its cycle. It is compared with
  // the oldest expectation that is still waiting.
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      results_in++;
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result slot_index=%0d hit=%b", $time, slot_index_o,
                 hit_o);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        if (hit_o === 1'b1) begin
          hits_seen++;
        end
        if (slot_index_o !== want.slot) begin
          $display("%0t: slot_index mismatch: expected %0d, actual %0d", $time, want.slot,
                   slot_index_o);
          errors++;
        end
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch: expected %b, actual %b", $time, want.hit, hit_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time,
               pending_picks.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // First fills of an empty store, at both extremes of the part number.
  // Afterward the same parts come back as hits.
  task automatic test_fill_and_hit();
    send_part(32'h0000_0000);
    send_part(32'hFFFF_FFFF);
    send_part(32'h0000_0000);
    send_part(32'hFFFF_FFFF);
    drain_results();
  endtask

  // With three live slots the store fills, and then misses evict the slot
  // whose last use is oldest. A hit in between renews the stamp of its slot.
  task automatic test_lru_eviction();
    set_live_slots(pblru_pkg::ACT_W'(3));
    send_part(32'h5A5A_A5A5);
    send_part(32'h8000_0001);
    send_part(32'hFFFF_FFFF);
    send_part(32'h7FFF_FFFE);
    send_part(32'h8000_0001);
    drain_results();
  endtask

  // A count of zero acts as one slot. A count above the slot total is
  // saturated. Slots that leave the live range keep their parts. When such a
  // part comes back in range, it can match in two slots, and the lower slot
  // must win.
  task automatic test_live_count();
    set_live_slots(pblru_pkg::ACT_W'(0));
    send_part(32'h1234_5678);
    send_part(32'h1234_5678);
    send_part(32'h7FFF_FFFE);
    set_live_slots(pblru_pkg::ACT_W'(31));
    send_part(32'h7FFF_FFFE);
    send_part(32'hFFFF_FFFF);
    send_part(32'hC3C3_3C3C);
    set_live_slots(pblru_pkg::ACT_W'(17));
    send_part(32'h0F0F_F0F0);
    set_live_slots(pblru_pkg::ACT_W'(1));
    send_part(32'h0F0F_F0F0);
    send_part(32'h0000_0000);
    set_live_slots(pblru_pkg::ACT_W'(16));
    send_part(32'h0000_0000);
    drain_results();
  endtask

  // Live counts are mostly small, so that the store fills and evicts often.
  // The extremes of the 5-bit register also come up now and then.
  function automatic logic [pblru_pkg::ACT_W-1:0] draw_live_count();
    case ($urandom_range(0, 9))
      0:       return pblru_pkg::ACT_W'(0);
      1:       return pblru_pkg::ACT_W'(1);
      2:       return pblru_pkg::ACT_W'(pblru_pkg::NUM_SLOTS);
      3:       return pblru_pkg::ACT_W'($urandom_range(pblru_pkg::NUM_SLOTS + 1,
                                                       (1 << pblru_pkg::ACT_W) - 1));
      4:       return pblru_pkg::ACT_W'($urandom_range(1, pblru_pkg::NUM_SLOTS));
      default: return pblru_pkg::ACT_W'($urandom_range(2, 6));
    endcase
  endfunction

  // The working set holds a few random part numbers. A request drawn from it
  // hits or evicts, depending on the set size against the live count.
  task automatic refresh_part_pool();
    int unsigned count;
    count = $urandom_range(1, 20);
    part_pool.delete();
    for (int i = 0; i < count; i++) begin
      part_pool.push_back($urandom());
    end
  endtask

  // Random traffic. Most requests come from the working set, so the
  // replacement logic is exercised in depth. The rest are random part numbers
  // that nearly always miss. The idle rate of the sender is set per phase.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_items);
    gap_pct = idle_pct;
    refresh_part_pool();
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 2) begin
        set_live_slots(draw_live_count());
      end
      if ($urandom_range(0, 49) == 0) begin
        refresh_part_pool();
      end
      if ($urandom_range(0, 99) < 80) begin
        send_part(part_pool[$urandom_range(0, part_pool.size() - 1)]);
      end else begin
        send_part($urandom());
      end
    end
    // Here the sender pauses until every expected result has arrived.
    drain_results();
    gap_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_hit();
    test_lru_eviction();
    test_live_count();
    test_random_traffic(13, ITEMS_PER_PHASE);
    test_random_traffic(55, ITEMS_PER_PHASE);
    test_random_traffic(0, ITEMS_PER_PHASE);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_picks.size() != 0) begin
      errors++;
    end

    $display("Sent %0d requests and checked %0d results (%0d hits).", items_sent,
             results_in, hits_seen);
    $display("Wrote the live slot count %0d times, including 0, 1, 16 and values above 16.",
             cfg_writes);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pblru_pkg.sv
rtl/pblru_store.sv
rtl/part_buffer_lru_select.sv
rtl/pblru_chk.sv
tb/sv/tb_top.sv
